@@ src/prcc_pkg.sv @@
// Shared types and constants for the parameter record CRC checker.
// Holds the record layout, default field values, CRC constants and status codes.
// No dependencies.
package prcc_pkg;

   // Record layout: ten 32-bit little-endian words, CRC over the first nine.
   localparam int unsigned RecWords  = 10;
   localparam logic [5:0]  RecBytes  = 6'd40;
   localparam logic [5:0]  CrcBytes  = 6'd36;
   localparam int unsigned WordIdx   = 4;

   // Reflected CRC-32 constants.
   localparam logic [31:0] CrcPoly   = 32'hEDB8_8320;
   localparam logic [31:0] CrcInit   = 32'hFFFF_FFFF;

   // Header words that a valid record must carry.
   localparam logic [31:0] RecMagic   = 32'h4349_4D43;
   localparam logic [31:0] RecVersion = 32'h0001_0001;

   // Values reported when the record is rejected.
   localparam logic [15:0] DefDevice  = 16'h0001;
   localparam logic [7:0]  DefBaud    = 8'h13;
   localparam logic [31:0] DefScale   = 32'h3F80_0000;
   localparam logic [31:0] DefLimitHi = 32'h453B_8000;
   localparam logic [31:0] DefLimitLo = 32'h42A0_0000;
   localparam logic [15:0] DefDac     = 16'h0000;

   // Load status codes.
   typedef enum logic [2:0] {
      STATUS_OK          = 3'd0,
      STATUS_BAD_LENGTH  = 3'd1,
      STATUS_BAD_MAGIC   = 3'd2,
      STATUS_BAD_VERSION = 3'd3,
      STATUS_BAD_CRC     = 3'd4
   } status_type;

   typedef logic [31:0] word_array_type [RecWords];

endpackage

@@ src/param_record_crc_checker.sv @@
// Top level of the parameter record CRC checker: byte capture, CRC and record check.
// Depends on prcc_pkg and prcc_crc_byte.
//
//   channel | direction | ports                                   | beat
//   req     | in        | req_data_byte, req_end_of_record        | one record byte
//   rsp     | out       | rsp_load_status and eight field ports   | one checked record
//
// One byte is taken every cycle while no final byte is held back; each byte passes an
// input register before it is folded into the CRC and the captured words.
// A record's result is registered: its final byte passes the input register and then loads the result register.
// Reset is synchronous and clears the byte count, CRC and overrun flag; the captured
// words need no clearing, since a record is only read back when all forty were written.
// A held result stalls only a final byte waiting behind it; other bytes keep flowing.
module param_record_crc_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_end_of_record,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_load_status,
   output logic [15:0] rsp_node_id,
   output logic [7:0]  rsp_baud_code,
   output logic [31:0] rsp_scale_first,
   output logic [31:0] rsp_scale_second,
   output logic [31:0] rsp_limit_first,
   output logic [31:0] rsp_limit_second,
   output logic [31:0] rsp_limit_third,
   output logic [15:0] rsp_dac_level
);

   // Input register.
   logic        in_valid_ff, in_valid_in;
   logic [7:0]  in_byte_ff;
   logic        in_eor_ff;

   // Record state.
   logic [5:0]  byte_count_ff, byte_count_in;
   logic [31:0] crc_ff, crc_in;
   logic        overrun_ff, overrun_in;
   prcc_pkg::word_array_type words_ff, words_in;

   // Result register.
   logic                 rsp_valid_ff, rsp_valid_in;
   prcc_pkg::status_type status_ff, status_in;
   logic [15:0] device_ff, device_in;
   logic [7:0]  baud_ff, baud_in;
   logic [31:0] scale0_ff, scale0_in, scale1_ff, scale1_in;
   logic [31:0] limit0_ff, limit0_in, limit1_ff, limit1_in, limit2_ff, limit2_in;
   logic [15:0] dac_ff, dac_in;

   logic        advance;
   logic        finish;
   logic        in_record;
   logic [31:0] crc_calc;
   logic [31:0] crc_new;
   logic [5:0]  count_new;
   logic        overrun_new;

   // The buffered byte moves on unless it closes a record and the result is held.
   assign advance   = in_valid_ff && (!in_eor_ff || !rsp_valid_ff || rsp_ready);
   assign finish    = advance && in_eor_ff;
   assign req_ready = !in_valid_ff || advance;

   assign in_valid_in = req_ready ? req_valid : in_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (req_ready) begin
         in_byte_ff <= req_data_byte;
         in_eor_ff  <= req_end_of_record;
      end
   end

   // CRC update of the buffered byte.
   prcc_crc_byte u_crc (
      .crc_cur   (crc_ff),
      .data_byte (in_byte_ff),
      .crc_next  (crc_calc)
   );

   assign in_record   = byte_count_ff < prcc_pkg::RecBytes;
   assign crc_new     = (byte_count_ff < prcc_pkg::CrcBytes) ? crc_calc : crc_ff;
   assign count_new   = in_record ? byte_count_ff + 6'd1 : byte_count_ff;
   assign overrun_new = overrun_ff || !in_record;

   // Merge the byte into its word and lane; bytes past the record are dropped.
   always_comb begin
      words_in = words_ff;
      for (int w = 0; w < prcc_pkg::RecWords; w++) begin
         for (int l = 0; l < 4; l++) begin
            if (in_record && byte_count_ff[5:2] == prcc_pkg::WordIdx'(w)
                  && byte_count_ff[1:0] == 2'(l)) begin
               words_in[w][8*l +: 8] = in_byte_ff;
            end
         end
      end
   end

   // Next record state; a closing byte returns the counters to their reset values.
   always_comb begin
      byte_count_in = byte_count_ff;
      crc_in        = crc_ff;
      overrun_in    = overrun_ff;
      if (advance) begin
         if (in_eor_ff) begin
            byte_count_in = 6'd0;
            crc_in        = prcc_pkg::CrcInit;
            overrun_in    = 1'b0;
         end else begin
            byte_count_in = count_new;
            crc_in        = crc_new;
            overrun_in    = overrun_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff <= 6'd0;
         crc_ff        <= prcc_pkg::CrcInit;
         overrun_ff    <= 1'b0;
      end else begin
         byte_count_ff <= byte_count_in;
         crc_ff        <= crc_in;
         overrun_ff    <= overrun_in;
      end
      if (advance) begin
         words_ff <= words_in;
      end
   end

   // Record check in priority order, then the loaded or default fields.
   always_comb begin
      if (overrun_new || count_new != prcc_pkg::RecBytes) begin
         status_in = prcc_pkg::STATUS_BAD_LENGTH;
      end else if (words_in[0] != prcc_pkg::RecMagic) begin
         status_in = prcc_pkg::STATUS_BAD_MAGIC;
      end else if (words_in[1] != prcc_pkg::RecVersion) begin
         status_in = prcc_pkg::STATUS_BAD_VERSION;
      end else if (words_in[9] != ~crc_new) begin
         status_in = prcc_pkg::STATUS_BAD_CRC;
      end else begin
         status_in = prcc_pkg::STATUS_OK;
      end

      if (status_in == prcc_pkg::STATUS_OK) begin
         device_in = words_in[2][15:0];
         baud_in   = words_in[2][23:16];
         scale0_in = words_in[3];
         scale1_in = words_in[4];
         limit0_in = words_in[5];
         limit1_in = words_in[6];
         limit2_in = words_in[7];
         dac_in    = words_in[8][15:0];
      end else begin
         device_in = prcc_pkg::DefDevice;
         baud_in   = prcc_pkg::DefBaud;
         scale0_in = prcc_pkg::DefScale;
         scale1_in = prcc_pkg::DefScale;
         limit0_in = prcc_pkg::DefLimitHi;
         limit1_in = prcc_pkg::DefLimitHi;
         limit2_in = prcc_pkg::DefLimitLo;
         dac_in    = prcc_pkg::DefDac;
      end
   end

   // Result register: loaded by a closing byte, cleared when taken.
   always_comb begin
      if (finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (finish) begin
         status_ff <= status_in;
         device_ff <= device_in;
         baud_ff   <= baud_in;
         scale0_ff <= scale0_in;
         scale1_ff <= scale1_in;
         limit0_ff <= limit0_in;
         limit1_ff <= limit1_in;
         limit2_ff <= limit2_in;
         dac_ff    <= dac_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_load_status  = status_ff;
   assign rsp_node_id      = device_ff;
   assign rsp_baud_code    = baud_ff;
   assign rsp_scale_first  = scale0_ff;
   assign rsp_scale_second = scale1_ff;
   assign rsp_limit_first  = limit0_ff;
   assign rsp_limit_second = limit1_ff;
   assign rsp_limit_third  = limit2_ff;
   assign rsp_dac_level    = dac_ff;

   // The byte count saturates at the record length.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      byte_count_ff <= prcc_pkg::RecBytes)
      else $error("byte count beyond record length");

   // An overrun can only be flagged once the record is full.
   a_overrun_full: assert property (@(posedge clock) disable iff (reset)
      overrun_ff |-> byte_count_ff == prcc_pkg::RecBytes)
      else $error("overrun flagged on a short record");

   // A closing byte leaves the record state at its reset values.
   a_restart: assert property (@(posedge clock) disable iff (reset)
      finish |=> (byte_count_ff == 6'd0 && crc_ff == prcc_pkg::CrcInit && !overrun_ff))
      else $error("record state not restarted after final byte");

   // A new result only appears after a closing byte was processed.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(finish))
      else $error("result raised without a final byte");

   // A rejected record carries the default fields.
   a_defaults: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && status_ff != prcc_pkg::STATUS_OK) |->
         (device_ff == prcc_pkg::DefDevice && baud_ff == prcc_pkg::DefBaud
          && dac_ff == prcc_pkg::DefDac))
      else $error("rejected record without default fields");

endmodule

@@ src/prcc_crc_byte.sv @@
// One-byte update of a reflected CRC-32, all eight bit steps combinational.
// Depends on prcc_pkg for the polynomial.
module prcc_crc_byte (
   input  logic [31:0] crc_cur,
   input  logic [7:0]  data_byte,
   output logic [31:0] crc_next
);

   // Fold the byte into the low end, then shift out eight bits.
   always_comb begin
      logic [31:0] acc;
      acc = crc_cur ^ {24'd0, data_byte};
      for (int k = 0; k < 8; k++) begin
         if (acc[0]) begin
            acc = (acc >> 1) ^ prcc_pkg::CrcPoly;
         end else begin
            acc = acc >> 1;
         end
      end
      crc_next = acc;
   end

endmodule
